// File: hw/rtl/rtuq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rtuq_pkg
// shared types and codes for the rank table: request and result payloads,
// opcodes, the controller states and the control word sent to every cell
// ----------------------------------------------------------------------------
package rtuq_pkg;

    localparam int SCORE_W = 32;

    localparam logic [1:0] OP_UPDATE = 2'd0;
    localparam logic [1:0] OP_RANK   = 2'd1;
    localparam logic [1:0] OP_SELECT = 2'd2;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [5:0]         slot;
        logic [SCORE_W-1:0] score;
        logic [6:0]         wanted_rank;
    } t_req;

    typedef struct packed {
        logic [6:0] answer;
        logic       error;
    } t_rsp;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_COUNT,
        ST_SCAN,
        ST_DONE
    } t_state;

    // control word broadcast to the row of cells
    typedef struct packed {
        logic load;   // copy the stored entry into the moving token
        logic shift;  // pass the token to the next cell
        logic count;  // add the "stored entry ranks above token" bit
    } t_cell_ctl;

endpackage : rtuq_pkg
`default_nettype wire

// File: hw/rtl/rtuq_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rtuq_cell
// one slot of the rank table: a stored score with its valid bit, plus a moving
// token register that travels around the ring and counts entries above it
// ----------------------------------------------------------------------------
module rtuq_cell
    import rtuq_pkg::*;
#(
    parameter int unsigned ENTRIES = 64,
    parameter int unsigned IDX     = 0,
    localparam int IW = $clog2(ENTRIES)
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  t_cell_ctl          i_ctl,
    input  wire                i_wr_en,
    input  wire  [SCORE_W-1:0] i_wr_score,
    input  wire                i_prev_valid,
    input  wire  [SCORE_W-1:0] i_prev_score,
    input  wire  [IW-1:0]      i_prev_tag,
    input  wire  [IW-1:0]      i_prev_cnt,
    output logic               o_tok_valid,
    output logic [SCORE_W-1:0] o_tok_score,
    output logic [IW-1:0]      o_tok_tag,
    output logic [IW-1:0]      o_tok_cnt
);

    logic               r_sv;
    logic [SCORE_W-1:0] r_ss;
    logic               r_mv;
    logic [SCORE_W-1:0] r_ms;
    logic [IW-1:0]      r_mt;
    logic [IW-1:0]      r_mc;
    logic               above;

    // stored entry ranks above the token: higher score, or same score and lower slot
    assign above = i_ctl.count && r_sv &&
                   ((r_ss > r_ms) || ((r_ss == r_ms) && (IW'(IDX) < r_mt)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv <= 1'b0;
        end else if (i_wr_en) begin
            r_sv <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_ss <= i_wr_score;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_mv <= r_sv;
            r_ms <= r_ss;
            r_mt <= IW'(IDX);
            r_mc <= '0;
        end else if (i_ctl.shift) begin
            r_mv <= i_prev_valid;
            r_ms <= i_prev_score;
            r_mt <= i_prev_tag;
            r_mc <= i_prev_cnt;
        end
    end

    assign o_tok_valid = r_mv;
    assign o_tok_score = r_ms;
    assign o_tok_tag   = r_mt;
    assign o_tok_cnt   = r_mc + IW'(above);

endmodule : rtuq_cell
`default_nettype wire

// File: hw/rtl/rank_table_update_query.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rank_table_update_query
// order-statistic table of scored slots: update a slot, ask the rank of a
// slot, or ask which slot holds a given rank
// ----------------------------------------------------------------------------
// usage
//   request channel: i_in_valid / o_in_stall / i_in_data, taken when valid is
//   high and stall is low. result channel: o_out_valid / i_out_stall /
//   o_out_data, one result per request, in request order.
//   an update writes the slot's cell directly when the request is taken; its
//   result passes through the done state into the output register.
//   a rank or slot-at-rank query loads a copy of every cell's entry as a token;
//   in the count state the tokens go once around the ring of cells, so each
//   token counts the entries ranked above it, then in the scan state the ring
//   turns once more past cell 0, where the controller picks the matching token.
//   the next request is taken once the controller is back in the idle state.
//   the ring rotation is what sets the query time; one request is in work at
//   a time, while the previous result may still sit in the output register.
//   reset (synchronous, active low) clears the stored valid bits and the handshake
//   state; scores need no reset since they are read only behind a valid bit.
//   when the receiver stalls, a finished result waits in the controller until
//   the output register frees up, and no new request is taken meanwhile.
// ----------------------------------------------------------------------------
module rank_table_update_query
    import rtuq_pkg::*;
#(
    parameter int unsigned ENTRIES = 64
) (
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_in_valid,
    output logic o_in_stall,
    input  t_req i_in_data,
    output logic o_out_valid,
    input  wire  i_out_stall,
    output t_rsp o_out_data
);

    localparam int IW   = $clog2(ENTRIES);
    // common width for comparing slot numbers and ranks
    localparam int CMPW = (IW + 1 > 7) ? IW + 1 : 7;

    // controller state
    t_state  r_state, n_state;
    logic [IW-1:0] r_step, n_step;
    t_req    r_req, n_req;
    t_rsp    r_res, n_res;
    logic    r_out_valid, n_out_valid;
    t_rsp    r_out, n_out;
    t_cell_ctl ctl;

    // ring taps
    logic               tok_valid [ENTRIES];
    logic [SCORE_W-1:0] tok_score [ENTRIES];
    logic [IW-1:0]      tok_tag   [ENTRIES];
    logic [IW-1:0]      tok_cnt   [ENTRIES];
    logic               wr_en     [ENTRIES];

    logic            in_take;
    logic            wr_go;
    logic            in_range;
    logic            step_last;
    logic [CMPW-1:0] head_tag;
    logic [CMPW-1:0] head_rank;
    logic            hit;

    assign o_in_stall = (r_state != ST_IDLE);
    assign in_take    = i_in_valid && !o_in_stall;
    assign wr_go      = in_take && (i_in_data.opcode == OP_UPDATE);
    assign in_range   = 32'(i_in_data.slot) < 32'(ENTRIES);
    assign step_last  = (r_step == IW'(ENTRIES - 1));

    // ring of cells, each fed by its left neighbor, cell 0 by the last one
    for (genvar j = 0; j < ENTRIES; j++) begin : g_cell
        localparam int unsigned PREV = (j == 0) ? ENTRIES - 1 : j - 1;

        assign wr_en[j] = wr_go && (32'(i_in_data.slot) == 32'(j));

        rtuq_cell #(
            .ENTRIES (ENTRIES),
            .IDX     (j)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (ctl),
            .i_wr_en      (wr_en[j]),
            .i_wr_score   (i_in_data.score),
            .i_prev_valid (tok_valid[PREV]),
            .i_prev_score (tok_score[PREV]),
            .i_prev_tag   (tok_tag[PREV]),
            .i_prev_cnt   (tok_cnt[PREV]),
            .o_tok_valid  (tok_valid[j]),
            .o_tok_score  (tok_score[j]),
            .o_tok_tag    (tok_tag[j]),
            .o_tok_cnt    (tok_cnt[j])
        );
    end

    // token sitting in cell 0 during the scan pass; counts are final by then
    assign head_tag  = CMPW'(tok_tag[0]);
    assign head_rank = CMPW'(tok_cnt[0]) + CMPW'(1);

    always_comb begin
        hit = 1'b0;
        case (r_req.opcode)
            OP_RANK:   hit = tok_valid[0] && (head_tag == CMPW'(r_req.slot));
            OP_SELECT: hit = tok_valid[0] && (head_rank == CMPW'(r_req.wanted_rank));
            default:   hit = 1'b0;
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_req       = r_req;
        n_res       = r_res;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        ctl         = '0;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_req  = i_in_data;
                    n_step = '0;
                    case (i_in_data.opcode)
                        OP_UPDATE: begin
                            n_res.answer = '0;
                            n_res.error  = !in_range;
                            n_state      = ST_DONE;
                        end
                        OP_RANK, OP_SELECT: begin
                            // error until a matching token shows up
                            n_res.answer = '0;
                            n_res.error  = 1'b1;
                            ctl.load     = 1'b1;
                            n_state      = ST_COUNT;
                        end
                        default: begin
                            n_res.answer = '0;
                            n_res.error  = 1'b1;
                            n_state      = ST_DONE;
                        end
                    endcase
                end
            end
            ST_COUNT: begin
                ctl.shift = 1'b1;
                ctl.count = 1'b1;
                n_step    = r_step + 1'b1;
                if (step_last) begin
                    n_step  = '0;
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                ctl.shift = 1'b1;
                n_step    = r_step + 1'b1;
                if (hit) begin
                    n_res.error = 1'b0;
                    case (r_req.opcode)
                        OP_RANK: n_res.answer = head_rank[6:0];
                        default: n_res.answer = head_tag[6:0];
                    endcase
                end
                if (step_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out       = r_res;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_step <= n_step;
        r_req  <= n_req;
        r_res  <= n_res;
        r_out  <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef ASSERT_OFF
    a_query_starts_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take && (i_in_data.opcode == OP_RANK || i_in_data.opcode == OP_SELECT)
        |=> r_state == ST_COUNT)
        else $error("query did not start the ring count");

    a_scan_ends_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) && step_last |=> r_state == ST_DONE)
        else $error("scan pass did not finish after one rotation");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state) == ST_DONE)
        else $error("result appeared outside the done state");

    a_error_zero_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.error |-> o_out_data.answer == '0)
        else $error("error result carries a nonzero answer");

    a_no_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !wr_go)
        else $error("table write while a query is in work");
`endif

endmodule : rank_table_update_query
`default_nettype wire
